FILE: rtl/keypad_calculator_entry_unit_defines.svh
// Assertion macros used by the top file to check its own logic.
`ifndef KEYPAD_CALCULATOR_ENTRY_UNIT_DEFINES_SVH
`define KEYPAD_CALCULATOR_ENTRY_UNIT_DEFINES_SVH

// Whenever the condition holds, the consequence must hold in the same cycle.
`define KCE_ASSERT_IMPLY(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error("keypad entry check failed");

// Whenever the condition holds, the consequence must hold in the next cycle.
`define KCE_ASSERT_NEXT(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error("keypad entry check failed");

`endif

FILE: rtl/kce_pkg.sv
package kce_pkg;

   // Key codes.
   localparam logic [7:0] KeyNone   = 8'd255;
   localparam logic [7:0] KeyClear  = 8'd13;
   localparam logic [7:0] KeyZero   = 8'h30;
   localparam logic [7:0] KeyNine   = 8'h39;
   localparam logic [7:0] KeyEquals = 8'h3D;
   localparam logic [7:0] KeyPlus   = 8'h2B;
   localparam logic [7:0] KeyMinus  = 8'h2D;
   localparam logic [7:0] KeyTimes  = 8'h2A;
   localparam logic [7:0] KeyDivide = 8'h2F;

   // Command classes handed from the front to the back.
   localparam logic [2:0] CmdStart  = 3'd0;
   localparam logic [2:0] CmdDigit  = 3'd1;
   localparam logic [2:0] CmdEquals = 3'd2;
   localparam logic [2:0] CmdClear  = 3'd3;
   localparam logic [2:0] CmdOper   = 3'd4;

   // Event codes reported on the result channel.
   localparam logic [2:0] EvStarted   = 3'd0;
   localparam logic [2:0] EvDigit     = 3'd1;
   localparam logic [2:0] EvOperator  = 3'd2;
   localparam logic [2:0] EvResult    = 3'd3;
   localparam logic [2:0] EvMathError = 3'd4;
   localparam logic [2:0] EvCleared   = 3'd5;

   // Command queue between the front and the back.
   localparam int QueueDepth = 2;
   localparam int QueuePtrW  = 1;
   localparam int QueueCntW  = 2;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] key;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   typedef struct packed {
      logic start;
      logic is_div;
   } md_req_type;

endpackage

FILE: rtl/kce_front.sv
module kce_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  logic [7:0]      req_key_sample,
   input  logic            q_full,
   output logic            cmd_wr,
   output kce_pkg::cmd_type cmd
);
   import kce_pkg::*;

   logic [7:0] held_ff, held_in;
   logic       started_ff, started_in;
   logic       accept;

   assign accept = push && !q_full;

   always_comb begin
      held_in    = held_ff;
      started_in = started_ff;
      cmd_wr     = 1'b0;
      cmd.key    = req_key_sample;
      cmd.kind   = CmdOper;
      if (accept) begin
         if (req_key_sample == KeyNone) begin
            held_in = KeyNone;
         end else if (req_key_sample != held_ff) begin
            held_in = req_key_sample;
            cmd_wr  = 1'b1;
         end
      end
      // The very first press after reset only wakes the calculator up.
      if (!started_ff) begin
         cmd.kind = CmdStart;
         if (cmd_wr) begin
            started_in = 1'b1;
         end
      end else if (req_key_sample >= KeyZero && req_key_sample <= KeyNine) begin
         cmd.kind = CmdDigit;
      end else if (req_key_sample == KeyEquals) begin
         cmd.kind = CmdEquals;
      end else if (req_key_sample == KeyClear) begin
         cmd.kind = CmdClear;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff    <= KeyNone;
         started_ff <= 1'b0;
      end else begin
         held_ff    <= held_in;
         started_ff <= started_in;
      end
   end

endmodule

FILE: rtl/kce_cmd_queue.sv
module kce_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr,
   input  kce_pkg::cmd_type  wr_cmd,
   input  logic              rd,
   output kce_pkg::cmd_type  head,
   output kce_pkg::qstat_type stat
);
   import kce_pkg::*;

   cmd_type                entry_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0]   count_ff, count_in;

   assign head       = entry_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == QueueCntW'(QueueDepth));
   assign stat.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (rd) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (wr && !rd) begin
         count_in = count_ff + 1'b1;
      end else if (rd && !wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         entry_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule

FILE: rtl/kce_muldiv.sv
module kce_muldiv (
   input  logic                clock,
   input  logic                reset,
   input  kce_pkg::md_req_type req,
   input  logic [31:0]         opa,
   input  logic [31:0]         opb,
   output logic                done,
   output logic [31:0]         result
);
   import kce_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        div_ff, div_in;
   logic        neg_ff, neg_in;
   logic [4:0]  step_ff, step_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] sh_ff, sh_in;
   logic [31:0] op_ff, op_in;
   logic [31:0] rem_ff, rem_in;
   logic [32:0] trial;
   logic [32:0] diff;

   assign trial  = {rem_ff, sh_ff[31]};
   assign diff   = trial - {1'b0, op_ff};
   assign done   = done_ff;
   assign result = (div_ff && neg_ff) ? (32'd0 - acc_ff) : acc_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      div_in  = div_ff;
      neg_in  = neg_ff;
      step_in = step_ff;
      acc_in  = acc_ff;
      sh_in   = sh_ff;
      op_in   = op_ff;
      rem_in  = rem_ff;
      if (req.start) begin
         // Division works on magnitudes and fixes the sign at the end.
         busy_in = 1'b1;
         div_in  = req.is_div;
         neg_in  = opa[31] ^ opb[31];
         step_in = '0;
         acc_in  = '0;
         rem_in  = '0;
         sh_in   = (req.is_div && opa[31]) ? (32'd0 - opa) : opa;
         op_in   = (req.is_div && opb[31]) ? (32'd0 - opb) : opb;
      end else if (busy_ff) begin
         step_in = step_ff + 1'b1;
         sh_in   = {sh_ff[30:0], 1'b0};
         if (div_ff) begin
            if (!diff[32]) begin
               rem_in = diff[31:0];
               acc_in = {acc_ff[30:0], 1'b1};
            end else begin
               rem_in = trial[31:0];
               acc_in = {acc_ff[30:0], 1'b0};
            end
         end else begin
            op_in = {1'b0, op_ff[31:1]};
            if (op_ff[0]) begin
               acc_in = acc_ff + sh_ff;
            end
         end
         if (step_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff  <= div_in;
      neg_ff  <= neg_in;
      step_ff <= step_in;
      acc_ff  <= acc_in;
      sh_ff   <= sh_in;
      op_ff   <= op_in;
      rem_ff  <= rem_in;
   end

endmodule

FILE: rtl/kce_back.sv
module kce_back #(
   parameter int MAX_DIGITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  kce_pkg::cmd_type      head,
   input  kce_pkg::qstat_type    qstat,
   output logic                  q_rd,
   output kce_pkg::md_req_type   md_req,
   output logic [31:0]           md_opa,
   output logic [31:0]           md_opb,
   input  logic                  md_done,
   input  logic [31:0]           md_result,
   output logic                  empty,
   input  logic                  pop,
   output logic [2:0]            rsp_event_kind,
   output logic signed [31:0]    rsp_shown_value,
   output logic                  rsp_second_operand_active
);
   import kce_pkg::*;

   localparam int CntW = $clog2(MAX_DIGITS + 1);

   localparam logic SIdle = 1'b0;
   localparam logic SWait = 1'b1;

   logic            state_ff, state_in;
   logic [31:0]     first_ff, first_in;
   logic [31:0]     second_ff, second_in;
   logic [CntW-1:0] cnt1_ff, cnt1_in;
   logic [CntW-1:0] cnt2_ff, cnt2_in;
   logic [7:0]      op_ff, op_in;
   logic            in2_ff, in2_in;
   logic [31:0]     last_ff, last_in;
   logic            out_valid_ff, out_valid_in;
   logic [2:0]      out_kind_ff, out_kind_in;
   logic [31:0]     out_value_ff, out_value_in;
   logic            out_in2_ff, out_in2_in;
   logic            out_free;

   // A digit on a negative operand grows its magnitude.
   function automatic logic [31:0] append_digit(input logic [31:0] v, input logic [3:0] d);
      logic [31:0] times10;
      times10 = {v[28:0], 3'b000} + {v[30:0], 1'b0};
      return v[31] ? (times10 - {28'd0, d}) : (times10 + {28'd0, d});
   endfunction

   assign out_free                  = !out_valid_ff || pop;
   assign q_rd                      = (state_ff == SIdle) && !qstat.empty && out_free;
   assign md_opa                    = first_ff;
   assign md_opb                    = second_ff;
   assign empty                     = !out_valid_ff;
   assign rsp_event_kind            = out_kind_ff;
   assign rsp_shown_value           = out_value_ff;
   assign rsp_second_operand_active = out_in2_ff;

   always_comb begin
      logic [3:0]  digit;
      logic        finish;
      logic [31:0] eq_value;
      logic        wipe;
      digit        = 4'(head.key - KeyZero);
      finish       = 1'b0;
      eq_value     = last_ff;
      wipe         = 1'b0;
      state_in     = state_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      cnt1_in      = cnt1_ff;
      cnt2_in      = cnt2_ff;
      op_in        = op_ff;
      in2_in       = in2_ff;
      last_in      = last_ff;
      out_valid_in = out_valid_ff && !pop;
      out_kind_in  = out_kind_ff;
      out_value_in = out_value_ff;
      out_in2_in   = out_in2_ff;
      md_req       = '0;
      if (state_ff == SWait) begin
         if (md_done) begin
            finish   = 1'b1;
            eq_value = md_result;
            state_in = SIdle;
         end
      end else if (q_rd) begin
         out_valid_in = 1'b1;
         out_value_in = '0;
         out_in2_in   = in2_ff;
         unique case (head.kind)
            CmdStart: begin
               out_kind_in = EvStarted;
            end
            CmdDigit: begin
               out_kind_in  = EvDigit;
               out_value_in = {28'd0, digit};
               if (!in2_ff) begin
                  if (cnt1_ff < CntW'(MAX_DIGITS)) begin
                     first_in = append_digit(first_ff, digit);
                     cnt1_in  = cnt1_ff + 1'b1;
                  end
               end else if (cnt2_ff < CntW'(MAX_DIGITS)) begin
                  second_in = append_digit(second_ff, digit);
                  cnt2_in   = cnt2_ff + 1'b1;
               end
            end
            CmdEquals: begin
               unique case (op_ff)
                  KeyPlus: begin
                     finish   = 1'b1;
                     eq_value = first_ff + second_ff;
                  end
                  KeyMinus: begin
                     finish   = 1'b1;
                     eq_value = first_ff - second_ff;
                  end
                  KeyTimes: begin
                     out_valid_in = 1'b0;
                     md_req.start = 1'b1;
                     state_in     = SWait;
                  end
                  KeyDivide: begin
                     if (second_ff == '0) begin
                        wipe        = 1'b1;
                        out_kind_in = EvMathError;
                     end else begin
                        out_valid_in  = 1'b0;
                        md_req.start  = 1'b1;
                        md_req.is_div = 1'b1;
                        state_in      = SWait;
                     end
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase
            end
            CmdClear: begin
               wipe        = 1'b1;
               out_kind_in = EvCleared;
            end
            CmdOper: begin
               op_in       = head.key;
               in2_in      = 1'b1;
               out_kind_in = EvOperator;
               out_in2_in  = 1'b1;
            end
            default: begin
               out_valid_in = 1'b0;
            end
         endcase
      end
      if (finish) begin
         last_in      = eq_value;
         first_in     = eq_value;
         second_in    = '0;
         cnt2_in      = '0;
         out_valid_in = 1'b1;
         out_kind_in  = EvResult;
         out_value_in = eq_value;
         out_in2_in   = in2_ff;
      end
      if (wipe) begin
         first_in   = '0;
         second_in  = '0;
         cnt1_in    = '0;
         cnt2_in    = '0;
         in2_in     = 1'b0;
         last_in    = '0;
         out_in2_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SIdle;
         first_ff     <= '0;
         second_ff    <= '0;
         cnt1_ff      <= '0;
         cnt2_ff      <= '0;
         op_ff        <= 8'd1;
         in2_ff       <= 1'b0;
         last_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         second_ff    <= second_in;
         cnt1_ff      <= cnt1_in;
         cnt2_ff      <= cnt2_in;
         op_ff        <= op_in;
         in2_ff       <= in2_in;
         last_ff      <= last_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_kind_ff  <= out_kind_in;
      out_value_ff <= out_value_in;
      out_in2_ff   <= out_in2_in;
   end

endmodule

FILE: rtl/keypad_calculator_entry_unit.sv
// Latency: an accepted key press passes the command queue entry and then the back
// end's output register; '=' with '*' or '/' also waits for the multiply/divide unit.
// Throughput: one poll sample per cycle while the command queue has room; the back
// end finishes one command per cycle while its output register is free or drained, but
// '*' and '/' hold it in the shift-and-add / restoring divide unit, the worst case.
// Reset: synchronous, active high; it returns the control registers to their idle values.
`include "keypad_calculator_entry_unit_defines.svh"

module keypad_calculator_entry_unit #(
   parameter int MAX_DIGITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [7:0]         req_key_sample,
   output logic               empty,
   input  logic               pop,
   output logic [2:0]         rsp_event_kind,
   output logic signed [31:0] rsp_shown_value,
   output logic               rsp_second_operand_active
);
   import kce_pkg::*;

   // The front filters repeated polls and classifies each new press into a command.
   // The queue lets the front keep taking poll beats while the back end is busy.
   cmd_type    front_cmd;
   logic       front_wr;
   cmd_type    q_head;
   qstat_type  q_stat;
   logic       q_rd;
   md_req_type md_req;
   logic [31:0] md_opa;
   logic [31:0] md_opb;
   logic        md_done;
   logic [31:0] md_result;

   // Every poll beat is accepted unless the command queue is full, including
   // samples that turn out to be no key or a key still held down.
   assign full = q_stat.full;

   kce_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .req_key_sample (req_key_sample),
      .q_full         (q_stat.full),
      .cmd_wr         (front_wr),
      .cmd            (front_cmd)
   );

   kce_cmd_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr     (front_wr),
      .wr_cmd (front_cmd),
      .rd     (q_rd),
      .head   (q_head),
      .stat   (q_stat)
   );

   // The back end holds the calculator state and a one-beat output register.
   // It takes a command only when that register is free or being drained.
   kce_back #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_back (
      .clock                     (clock),
      .reset                     (reset),
      .head                      (q_head),
      .qstat                     (q_stat),
      .q_rd                      (q_rd),
      .md_req                    (md_req),
      .md_opa                    (md_opa),
      .md_opb                    (md_opb),
      .md_done                   (md_done),
      .md_result                 (md_result),
      .empty                     (empty),
      .pop                       (pop),
      .rsp_event_kind            (rsp_event_kind),
      .rsp_shown_value           (rsp_shown_value),
      .rsp_second_operand_active (rsp_second_operand_active)
   );

   // One bit per cycle: the multiply adds a shifted operand, the divide subtracts trial
   // remainders, both over 32 steps.
   kce_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .req    (md_req),
      .opa    (md_opa),
      .opb    (md_opb),
      .done   (md_done),
      .result (md_result)
   );

   // The front never writes a full queue and the back never reads an empty one.
   `KCE_ASSERT_IMPLY(a_queue_no_overflow, clock, reset, front_wr, !q_stat.full)
   `KCE_ASSERT_IMPLY(a_queue_no_underflow, clock, reset, q_rd, !q_stat.empty)
   // A multiply or divide is never started while the output register still holds a beat.
   `KCE_ASSERT_NEXT(a_md_start_output_free, clock, reset, md_req.start, empty)
   // An operator event always reports a zero value with the second operand active.
   `KCE_ASSERT_IMPLY(a_operator_event_shape, clock, reset,
      !empty && rsp_event_kind == EvOperator,
      rsp_shown_value == 32'sd0 && rsp_second_operand_active)

endmodule
